// ===== rtl/vtr_pkg.sv =====
package vtr_pkg;

  localparam int COMP_WIDTH_DEF = 32;
  localparam int COEF_WIDTH_DEF = 18;

  typedef enum logic [1:0] {
    MODE_PLANE_STRESS = 2'd0,
    MODE_PLANE_STRAIN = 2'd1,
    MODE_FULL_3D      = 2'd2,
    MODE_SPARE        = 2'd3
  } tensor_mode_t;

  localparam tensor_mode_t MODE_RESET = MODE_FULL_3D;

  localparam int NUM_COMP = 6;
  localparam int NUM_DIM  = 3;

  // output entries of C: 00, 11, 22, 01, 12, 02
  localparam int ENT_I [NUM_COMP] = '{0, 1, 2, 0, 1, 0};
  localparam int ENT_J [NUM_COMP] = '{0, 1, 2, 1, 2, 2};

endpackage

// ===== rtl/voigt_tensor_rotation_core.sv =====
// Symmetric tensor rotation in Voigt form, one tensor per transaction.
// Slave stream: tdata carries comp_0..comp_5 (signed Q16.16) then row_0..row_2
// (three signed Q1.16 coefficients each, column 0 lowest); tuser is op
// (0: T^T A T, 1: T A T^T).
// Master stream: tdata carries res_0..res_5; tuser is the saturation flag.
// cfg_we/cfg_wdata write tensor_mode (0 plane stress, 1 plane strain,
// 2 or 3 full 3D); write only while the pipeline is empty.
// An input transaction reaches output valid through six register stages:
// input register, first product bank, first round, second product bank,
// second round, output register. Throughput is one transaction per cycle
// unless the receiver stalls; the 27 + 18 multipliers each form one stage.
// Reset clears all stage valid bits and sets tensor_mode to 3D.
// When the receiver stalls with a valid output, the whole pipeline holds and
// s_axis_tready drops in the same cycle; nothing is lost or repeated.
module voigt_tensor_rotation_core #(
  parameter int COMP_WIDTH = vtr_pkg::COMP_WIDTH_DEF,
  parameter int COEF_WIDTH = vtr_pkg::COEF_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // comp_0..comp_5, row_0, row_1, row_2, zero pad
  input  logic [((6*COMP_WIDTH+9*COEF_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // op
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // res_0..res_5
  output logic [6*COMP_WIDTH-1:0] m_axis_tdata,
  // overflow
  output logic m_axis_tuser,
  input  logic cfg_we,
  input  logic [1:0] cfg_wdata
);
  import vtr_pkg::*;

  localparam int W   = COMP_WIDTH;
  localparam int K   = COEF_WIDTH;
  localparam int F   = COEF_WIDTH - 2;
  localparam int P1  = W + K;
  localparam int S1  = W + K + 2;
  localparam int BW  = S1 - F;
  localparam int P2  = BW + K;
  localparam int S2  = P2 + 2;
  localparam int CW  = S2 - F;
  localparam int ROW = 6 * W;

  tensor_mode_t mode;
  logic [5:0] vld;
  tensor_mode_t md [5];
  logic ce;

  logic signed [W-1:0] a0 [NUM_DIM][NUM_DIM];
  logic signed [K-1:0] m0 [NUM_DIM][NUM_DIM];
  logic signed [P1-1:0] pb [NUM_DIM][NUM_DIM][NUM_DIM];
  logic signed [K-1:0] m1 [NUM_DIM][NUM_DIM];
  logic signed [BW-1:0] b2 [NUM_DIM][NUM_DIM];
  logic signed [K-1:0] m2 [NUM_DIM][NUM_DIM];
  logic signed [P2-1:0] pc [NUM_COMP][NUM_DIM];
  logic signed [CW-1:0] c4 [NUM_COMP];
  logic signed [W-1:0] sat [NUM_COMP];
  logic [NUM_COMP-1:0] ovf;

  logic signed [W-1:0] cin [NUM_COMP];
  logic signed [K-1:0] tin [NUM_DIM][NUM_DIM];
  logic signed [W-1:0] a_next [NUM_DIM][NUM_DIM];

  logic [6*W-1:0] res_next;
  logic ovf_next;

  assign ce = !vld[5] || m_axis_tready;
  assign s_axis_tready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
    end else if (cfg_we) begin
      mode <= tensor_mode_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[4:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      md[0] <= mode;
      for (int s = 1; s < 5; s++) begin
        md[s] <= md[s-1];
      end
    end
  end

  genvar gi, gj, gk;
  generate
    for (gi = 0; gi < NUM_COMP; gi++) begin : g_cin
      assign cin[gi] = s_axis_tdata[gi*W +: W];
    end
    for (gi = 0; gi < NUM_DIM; gi++) begin : g_tin_r
      for (gj = 0; gj < NUM_DIM; gj++) begin : g_tin_c
        assign tin[gi][gj] = s_axis_tdata[ROW + gi*3*K + gj*K +: K];
      end
    end
  endgenerate

  always_comb begin
    for (int i = 0; i < NUM_DIM; i++) begin
      for (int j = 0; j < NUM_DIM; j++) begin
        a_next[i][j] = '0;
      end
    end
    a_next[0][0] = cin[0];
    a_next[1][1] = cin[1];
    unique case (mode)
      MODE_PLANE_STRESS: begin
        a_next[0][1] = cin[2];
      end
      MODE_PLANE_STRAIN: begin
        a_next[2][2] = cin[2];
        a_next[0][1] = cin[3];
      end
      default: begin
        a_next[2][2] = cin[2];
        a_next[1][2] = cin[3];
        a_next[0][2] = cin[4];
        a_next[0][1] = cin[5];
      end
    endcase
    a_next[1][0] = a_next[0][1];
    a_next[2][0] = a_next[0][2];
    a_next[2][1] = a_next[1][2];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < NUM_DIM; i++) begin
        for (int j = 0; j < NUM_DIM; j++) begin
          a0[i][j] <= a_next[i][j];
          m0[i][j] <= s_axis_tuser ? tin[i][j] : tin[j][i];
        end
      end
    end
  end

  // first product bank: M * A
  generate
    for (gi = 0; gi < NUM_DIM; gi++) begin : g_b_i
      for (gj = 0; gj < NUM_DIM; gj++) begin : g_b_j
        logic signed [S1-1:0] sum1;
        logic signed [S1-1:0] rnd1;
        for (gk = 0; gk < NUM_DIM; gk++) begin : g_b_k
          always_ff @(posedge clk) begin
            if (ce) begin
              pb[gi][gj][gk] <= P1'(m0[gi][gk] * a0[gk][gj]);
            end
          end
        end
        assign sum1 = S1'(pb[gi][gj][0]) + S1'(pb[gi][gj][1]) + S1'(pb[gi][gj][2]);
        assign rnd1 = (sum1 + (S1'(1) <<< (F - 1))) >>> F;
        always_ff @(posedge clk) begin
          if (ce) begin
            m1[gi][gj] <= m0[gi][gj];
            m2[gi][gj] <= m1[gi][gj];
            b2[gi][gj] <= rnd1[BW-1:0];
          end
        end
      end
    end

    // second product bank: B * M^T, upper-triangle entries only
    for (gi = 0; gi < NUM_COMP; gi++) begin : g_c_e
      logic signed [S2-1:0] sum2;
      logic signed [S2-1:0] rnd2;
      for (gk = 0; gk < NUM_DIM; gk++) begin : g_c_k
        always_ff @(posedge clk) begin
          if (ce) begin
            pc[gi][gk] <= P2'(b2[ENT_I[gi]][gk] * m2[ENT_J[gi]][gk]);
          end
        end
      end
      assign sum2 = S2'(pc[gi][0]) + S2'(pc[gi][1]) + S2'(pc[gi][2]);
      assign rnd2 = (sum2 + (S2'(1) <<< (F - 1))) >>> F;
      always_ff @(posedge clk) begin
        if (ce) begin
          c4[gi] <= rnd2[CW-1:0];
        end
      end
      assign ovf[gi] = !((&c4[gi][CW-1:W-1]) || !(|c4[gi][CW-1:W-1]));
      assign sat[gi] = !ovf[gi] ? c4[gi][W-1:0] :
                       (c4[gi][CW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}});
    end
  endgenerate

  always_comb begin
    res_next = '0;
    res_next[0 +: W] = sat[0];
    res_next[W +: W] = sat[1];
    unique case (md[4])
      MODE_PLANE_STRESS: begin
        res_next[2*W +: W] = sat[3];
        ovf_next = ovf[0] || ovf[1] || ovf[3];
      end
      MODE_PLANE_STRAIN: begin
        res_next[2*W +: W] = sat[2];
        res_next[3*W +: W] = sat[3];
        ovf_next = ovf[0] || ovf[1] || ovf[2] || ovf[3];
      end
      default: begin
        res_next[2*W +: W] = sat[2];
        res_next[3*W +: W] = sat[4];
        res_next[4*W +: W] = sat[5];
        res_next[5*W +: W] = sat[3];
        ovf_next = |ovf;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m_axis_tdata <= res_next;
      m_axis_tuser <= ovf_next;
    end
  end

  assign m_axis_tvalid = vld[5];

endmodule

// ===== rtl/vtr_checker.sv =====
module vtr_checker #(
  parameter int COMP_WIDTH = vtr_pkg::COMP_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [6*COMP_WIDTH-1:0] m_axis_tdata,
  input logic m_axis_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output changed during stall");

endmodule

bind voigt_tensor_rotation_core vtr_checker #(.COMP_WIDTH(COMP_WIDTH)) u_vtr_checker (.*);

// ===== tb/sv/tb_voigt_tensor_rotation_core.sv =====
`timescale 1ns / 100ps

module tb_voigt_tensor_rotation_core;
  import vtr_pkg::*;

  localparam int DW = ((6*32+9*18+7)/8)*8;

  typedef struct packed {
    bit ovf;
    logic [191:0] res;
  } rot_result_t;

  class rotation_scoreboard;
    tensor_mode_t mode = MODE_RESET;
    rot_result_t pending[$];
    int errors = 0;
    int checked = 0;
    int saturated = 0;

    function logic [31:0] clamp(longint v, inout bit ovf);
      if (v > 64'sd2147483647) begin
        ovf = 1;
        return 32'h7fffffff;
      end
      if (v < -64'sd2147483648) begin
        ovf = 1;
        return 32'h80000000;
      end
      return v[31:0];
    endfunction

    function void note_tensor(logic [DW-1:0] d, logic op);
      longint t[3][3], m[3][3], a[3][3], b[3][3], c[3][3], comp[6], acc;
      int n;
      bit ovf;
      rot_result_t e;
      ovf = 0;
      e = '0;
      for (int i = 0; i < 6; i++) comp[i] = longint'($signed(d[32*i +: 32]));
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          t[i][j] = longint'($signed(d[192 + 54*i + 18*j +: 18]));
          a[i][j] = 0;
        end
      a[0][0] = comp[0];
      a[1][1] = comp[1];
      if (mode == MODE_PLANE_STRESS) begin
        n = 2;
        a[0][1] = comp[2];
        a[1][0] = comp[2];
      end else if (mode == MODE_PLANE_STRAIN) begin
        n = 3;
        a[2][2] = comp[2];
        a[0][1] = comp[3];
        a[1][0] = comp[3];
      end else begin
        n = 3;
        a[2][2] = comp[2];
        a[1][2] = comp[3];
        a[2][1] = comp[3];
        a[0][2] = comp[4];
        a[2][0] = comp[4];
        a[0][1] = comp[5];
        a[1][0] = comp[5];
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) m[i][j] = op ? t[i][j] : t[j][i];
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          acc = 0;
          for (int k = 0; k < n; k++) acc += m[i][k] * a[k][j];
          b[i][j] = (acc + 64'sd32768) >>> 16;
        end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          acc = 0;
          for (int k = 0; k < n; k++) acc += b[i][k] * m[j][k];
          c[i][j] = (acc + 64'sd32768) >>> 16;
        end
      e.res[31:0] = clamp(c[0][0], ovf);
      e.res[63:32] = clamp(c[1][1], ovf);
      if (mode == MODE_PLANE_STRESS) begin
        e.res[95:64] = clamp(c[0][1], ovf);
      end else if (mode == MODE_PLANE_STRAIN) begin
        e.res[95:64] = clamp(c[2][2], ovf);
        e.res[127:96] = clamp(c[0][1], ovf);
      end else begin
        e.res[95:64] = clamp(c[2][2], ovf);
        e.res[127:96] = clamp(c[1][2], ovf);
        e.res[159:128] = clamp(c[0][2], ovf);
        e.res[191:160] = clamp(c[0][1], ovf);
      end
      e.ovf = ovf;
      if (ovf) saturated++;
      pending.push_back(e);
    endfunction

    function void check_result(logic [191:0] res, logic ovf);
      rot_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h ovf %b", $time, res, ovf);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      for (int i = 0; i < 6; i++)
        if (res[32*i +: 32] !== e.res[32*i +: 32]) begin
          $display("%0t: res_%0d expected %h actual %h", $time, i,
                   e.res[32*i +: 32], res[32*i +: 32]);
          errors++;
        end
      if (ovf !== e.ovf) begin
        $display("%0t: overflow expected %b actual %b", $time, e.ovf, ovf);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [191:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_we = 0;
  logic [1:0] cfg_wdata = '0;

  rotation_scoreboard sb = new();
  bit calm = 0;
  int stall_cnt = 0;
  int idle_cycles = 0;

  voigt_tensor_rotation_core dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  function int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function logic [31:0] pick_comp();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  function logic [17:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return 18'($urandom);
      1: return $urandom_range(0, 1) ? 18'h1ffff : 18'h20000;
      default: return 18'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function logic [DW-1:0] build(logic [31:0] cv, logic [17:0] kv, bit rnd);
    logic [DW-1:0] d;
    d = '0;
    for (int i = 0; i < 6; i++) d[32*i +: 32] = rnd ? pick_comp() : cv;
    for (int i = 0; i < 9; i++) d[192 + 18*i +: 18] = rnd ? pick_coef() : kv;
    return d;
  endfunction

  task automatic send_tensor(logic [DW-1:0] d, logic op);
    int gap;
    gap = calm ? 0 : ($urandom_range(0, 2) == 0 ? pick_gap() : 0);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata <= d;
    s_axis_tuser <= op;
    s_axis_tvalid <= 1;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_mode(tensor_mode_t md);
    drain();
    cfg_we <= 1;
    cfg_wdata <= md;
    @(posedge clk);
    cfg_we <= 0;
    sb.mode = md;
  endtask

  task automatic run_phase();
    logic [DW-1:0] d;
    d = '0;
    send_tensor(d, 0);
    send_tensor(build(32'h7fffffff, 18'h10000, 0), 0);
    send_tensor(build(32'h80000000, 18'h20000, 0), 1);
    send_tensor(build(32'h7fffffff, 18'h1ffff, 0), 1);
    send_tensor(build(32'hffffffff, 18'h3ffff, 0), 0);
    send_tensor({DW{1'b1}} >> (DW - 354), 1);
    calm = 1;
    for (int i = 0; i < 114; i++) begin
      if (i == 30) calm = 0;
      send_tensor(build('0, '0, 1), 1'($urandom));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 0;
    end else if (calm) begin
      m_axis_tready <= 1;
    end else if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
      m_axis_tready <= 0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_cnt <= pick_gap();
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_tensor(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("tb_voigt_tensor_rotation_core: errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    run_phase();
    write_mode(MODE_PLANE_STRESS);
    run_phase();
    write_mode(MODE_PLANE_STRAIN);
    run_phase();
    write_mode(MODE_SPARE);
    run_phase();
    write_mode(MODE_FULL_3D);
    run_phase();
    drain();
    $display("covered all four mode values, both directions, extreme components and");
    $display("coefficients: %0d results checked, %0d saturated", sb.checked, sb.saturated);
    if (sb.errors == 0) begin
      $display("tb_voigt_tensor_rotation_core: clean");
    end else begin
      $display("tb_voigt_tensor_rotation_core: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vtr_pkg.sv
rtl/voigt_tensor_rotation_core.sv
rtl/vtr_checker.sv
tb/sv/tb_voigt_tensor_rotation_core.sv
